[hdl/lslf_pkg.sv]
// Shared types, constants and helpers for the least-squares line fit block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lslf_pkg;

  localparam int unsigned MAX_PAIRS = 65536;
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 72;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam int OPND_W = 48;
  localparam int DIGIT_W = 16;
  localparam int PP_W = OPND_W + DIGIT_W;
  localparam int PROD_W = 80;

  localparam int DEN_W = 64;
  localparam int SLOPE_EXTRA = 16;
  localparam int ICPT_EXTRA = 8;
  localparam int DIV_BITS = PROD_W + ICPT_EXTRA;
  localparam int DCNT_W = $clog2(DIV_BITS);
  localparam int QUO_W = 33;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_DEGENERATE = 2'd1,
    STATUS_LIMIT      = 2'd2
  } lslf_status_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [32:0]      sx;
    logic [32:0]      sy;
    logic [46:0]      sxx;
    logic [47:0]      sxy;
    logic             limit;
  } lslf_sums_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lslf_unit_sts_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DEN_A,
    BK_DEN_B,
    BK_SN_A,
    BK_SN_B,
    BK_IN_A,
    BK_IN_B,
    BK_DIV_S,
    BK_DIV_I,
    BK_OUT
  } lslf_back_state_t;

  // Sign and magnitude to saturated Q16.16; big means magnitude >= 2^32.
  function automatic logic [31:0] to_q1616(input logic neg, input logic big,
                                           input logic [31:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (big || mag[31]) ? 32'h7FFF_FFFF : mag;
    end else begin
      res = (big || mag[31]) ? 32'h8000_0000 : (32'd0 - mag);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/lslf_front.sv]
// Front end: takes sample pairs, squares and multiplies them, keeps the running sums.
// Pushes a snapshot of the sums on each last pair. Depends on lslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lslf_front import lslf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tlast,
  output logic                  push,
  output lslf_sums_t            push_data,
  input  logic                  full
);

  logic               s1_valid;
  logic               s1_last;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_y;
  logic signed [31:0] s1_xx;
  logic signed [31:0] s1_xy;

  logic signed [15:0] x_in;
  logic signed [15:0] y_in;
  logic signed [31:0] xx_in;
  logic signed [31:0] xy_in;

  logic [CNT_W-1:0] count;
  logic [32:0]      sx;
  logic [32:0]      sy;
  logic [46:0]      sxx;
  logic [47:0]      sxy;
  logic             limit;

  logic       s1_fire;
  logic       take;
  lslf_sums_t sums_next;

  assign x_in  = s_tdata[15:0];
  assign y_in  = s_tdata[31:16];
  assign xx_in = x_in * x_in;
  assign xy_in = x_in * y_in;

  assign s1_fire  = s1_valid && !(s1_last && full);
  assign s_tready = !s1_valid || s1_fire;
  assign take     = (count != CNT_W'(MAX_PAIRS));

  always_comb begin
    sums_next.n     = count + CNT_W'(take);
    sums_next.sx    = take ? sx + {{17{s1_x[15]}}, s1_x} : sx;
    sums_next.sy    = take ? sy + {{17{s1_y[15]}}, s1_y} : sy;
    sums_next.sxx   = take ? sxx + {16'd0, s1_xx[30:0]} : sxx;
    sums_next.sxy   = take ? sxy + {{16{s1_xy[31]}}, s1_xy} : sxy;
    sums_next.limit = limit || !take;
  end

  assign push      = s1_fire && s1_last;
  assign push_data = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count    <= '0;
      sx       <= '0;
      sy       <= '0;
      sxx      <= '0;
      sxy      <= '0;
      limit    <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_fire) begin
        if (s1_last) begin
          count <= '0;
          sx    <= '0;
          sy    <= '0;
          sxx   <= '0;
          sxy   <= '0;
          limit <= 1'b0;
        end else begin
          count <= sums_next.n;
          sx    <= sums_next.sx;
          sy    <= sums_next.sy;
          sxx   <= sums_next.sxx;
          sxy   <= sums_next.sxy;
          limit <= sums_next.limit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_x    <= x_in;
      s1_y    <= y_in;
      s1_last <= s_tlast;
      s1_xx   <= xx_in;
      s1_xy   <= xy_in;
    end
  end

endmodule

`default_nettype wire

[hdl/lslf_queue.sv]
// Short queue of sum snapshots between the accumulating front and the fitting back.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lslf_queue import lslf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lslf_sums_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output lslf_sums_t pop_data
);

  lslf_sums_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign full     = (fill == (QPTR_W + 1)'(QDEPTH));
  assign valid    = (fill != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hdl/lslf_mul.sv]
// Serial signed multiplier: one operand digit of 16 bits per cycle, registered partials.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lslf_mul import lslf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OPND_W-1:0] a,
  input  logic [OPND_W-1:0] b,
  output lslf_unit_sts_t    sts,
  output logic [PROD_W-1:0] result
);

  logic                busy;
  logic                done;
  logic [1:0]          step;
  logic [OPND_W-1:0]   mag_a;
  logic [OPND_W-1:0]   mag_b;
  logic                neg;
  logic [PP_W-1:0]     pp;
  logic [PROD_W-1:0]   acc;
  logic [DIGIT_W-1:0]  digit;
  logic [PROD_W-1:0]   pp_shifted;

  always_comb begin
    case (step)
      2'd0:    digit = mag_b[DIGIT_W-1:0];
      2'd1:    digit = mag_b[2*DIGIT_W-1:DIGIT_W];
      2'd2:    digit = mag_b[3*DIGIT_W-1:2*DIGIT_W];
      default: digit = '0;
    endcase
  end

  always_comb begin
    case (step)
      2'd1:    pp_shifted = PROD_W'(pp);
      2'd2:    pp_shifted = PROD_W'(pp) << DIGIT_W;
      2'd3:    pp_shifted = PROD_W'(pp) << (2 * DIGIT_W);
      default: pp_shifted = '0;
    endcase
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = neg ? (PROD_W'(0) - acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_a <= a[OPND_W-1] ? (OPND_W'(0) - a) : a;
      mag_b <= b[OPND_W-1] ? (OPND_W'(0) - b) : b;
      neg   <= a[OPND_W-1] ^ b[OPND_W-1];
      acc   <= '0;
    end else if (busy) begin
      if (step != 2'd3) begin
        pp <= mag_a * digit;
      end
      if (step != 2'd0) begin
        acc <= acc + pp_shifted;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/lslf_div.sv]
// Restoring divider, one dividend bit per cycle, quotient cut to 32 bits with an overflow flag.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lslf_div import lslf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DEN_W-1:0]    divisor,
  output lslf_unit_sts_t      sts,
  output logic [31:0]         quo,
  output logic                big
);

  logic                busy;
  logic                done;
  logic [DCNT_W-1:0]   cnt;
  logic [DIV_BITS-1:0] dvd;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    rem;
  logic [QUO_W-1:0]    q;
  logic                ovf;
  logic [DEN_W-1:0]    trial;
  logic                ge;

  assign trial    = {rem[DEN_W-2:0], dvd[DIV_BITS-1]};
  assign ge       = (trial >= den);
  assign sts.busy = busy;
  assign sts.done = done;
  assign quo      = q[31:0];
  assign big      = ovf || q[QUO_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DCNT_W'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      den <= divisor;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= ge ? (trial - den) : trial;
      q   <= {q[QUO_W-2:0], ge};
      ovf <= ovf || q[QUO_W-1];
    end
  end

endmodule

`default_nettype wire

[hdl/lslf_back.sv]
// Back end: sequences the serial multiplier and divider over one sum snapshot,
// saturates the fit and holds it in the output register. Depends on lslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lslf_back import lslf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  lslf_sums_t             q_data,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  lslf_back_state_t state;
  lslf_back_state_t state_next;

  lslf_sums_t          w;
  logic [PROD_W-1:0]   first;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    snum;
  logic [PROD_W-1:0]   inum;
  logic [31:0]         slope_r;
  logic [31:0]         icpt_r;
  lslf_status_t        status_r;

  logic                mul_start;
  logic [OPND_W-1:0]   mul_a;
  logic [OPND_W-1:0]   mul_b;
  lslf_unit_sts_t      mul_sts;
  logic [PROD_W-1:0]   mul_res;
  logic                div_start;
  logic [DIV_BITS-1:0] div_dvd;
  lslf_unit_sts_t      div_sts;
  logic [31:0]         div_quo;
  logic                div_big;

  logic [PROD_W-1:0]   diff;
  logic                diff_zero;
  logic [DEN_W-1:0]    snum_mag;
  logic [PROD_W-1:0]   inum_mag;
  logic                out_load;
  logic [OPND_W-1:0]   op_n;
  logic [OPND_W-1:0]   op_sx;
  logic [OPND_W-1:0]   op_sy;
  logic [OPND_W-1:0]   op_sxx;
  logic [OPND_W-1:0]   op_sxy;

  assign diff      = first - mul_res;
  assign diff_zero = (diff == '0);
  assign snum_mag  = snum[DEN_W-1] ? (DEN_W'(0) - snum) : snum;
  assign inum_mag  = inum[PROD_W-1] ? (PROD_W'(0) - inum) : inum;

  assign op_n   = {{(OPND_W - CNT_W){1'b0}}, w.n};
  assign op_sx  = {{(OPND_W - 33){w.sx[32]}}, w.sx};
  assign op_sy  = {{(OPND_W - 33){w.sy[32]}}, w.sy};
  assign op_sxx = {{(OPND_W - 47){1'b0}}, w.sxx};
  assign op_sxy = w.sxy;

  lslf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .sts    (mul_sts),
    .result (mul_res)
  );

  lslf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (den),
    .sts      (div_sts),
    .quo      (div_quo),
    .big      (div_big)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (q_valid) state_next = BK_DEN_A;
      BK_DEN_A: if (mul_sts.done) state_next = BK_DEN_B;
      BK_DEN_B: begin
        if (mul_sts.done) state_next = diff_zero ? BK_OUT : BK_SN_A;
      end
      BK_SN_A:  if (mul_sts.done) state_next = BK_SN_B;
      BK_SN_B:  if (mul_sts.done) state_next = BK_IN_A;
      BK_IN_A:  if (mul_sts.done) state_next = BK_IN_B;
      BK_IN_B:  if (mul_sts.done) state_next = BK_DIV_S;
      BK_DIV_S: if (div_sts.done) state_next = BK_DIV_I;
      BK_DIV_I: if (div_sts.done) state_next = BK_OUT;
      BK_OUT:   if (!m_tvalid || m_tready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = op_n;
    mul_b     = op_sxx;
    div_dvd   = {{(DIV_BITS - DEN_W - SLOPE_EXTRA){1'b0}}, snum_mag, {SLOPE_EXTRA{1'b0}}};
    unique case (state) inside
      BK_IDLE: q_pop = q_valid;
      BK_DEN_A, BK_DEN_B, BK_SN_A, BK_SN_B, BK_IN_A, BK_IN_B: begin
        mul_start = !mul_sts.busy && !mul_sts.done;
        unique case (state) inside
          BK_DEN_A: begin mul_a = op_n;   mul_b = op_sxx; end
          BK_DEN_B: begin mul_a = op_sx;  mul_b = op_sx;  end
          BK_SN_A:  begin mul_a = op_n;   mul_b = op_sxy; end
          BK_SN_B:  begin mul_a = op_sx;  mul_b = op_sy;  end
          BK_IN_A:  begin mul_a = op_sxx; mul_b = op_sy;  end
          default:  begin mul_a = op_sx;  mul_b = op_sxy; end
        endcase
      end
      BK_DIV_S: div_start = !div_sts.busy && !div_sts.done;
      BK_DIV_I: begin
        div_start = !div_sts.busy && !div_sts.done;
        div_dvd   = {inum_mag, {ICPT_EXTRA{1'b0}}};
      end
      BK_OUT:  out_load = !m_tvalid || m_tready;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w <= q_data;
    end
    if (mul_sts.done) begin
      unique case (state) inside
        BK_DEN_A, BK_SN_A, BK_IN_A: first <= mul_res;
        BK_DEN_B: begin
          den <= diff[DEN_W-1:0];
          if (diff_zero) begin
            slope_r  <= '0;
            icpt_r   <= '0;
            status_r <= STATUS_DEGENERATE;
          end
        end
        BK_SN_B: snum <= diff[DEN_W-1:0];
        BK_IN_B: inum <= diff;
        default: first <= first;
      endcase
    end
    if (div_sts.done) begin
      if (state == BK_DIV_S) begin
        slope_r <= to_q1616(snum[DEN_W-1], div_big, div_quo);
      end else begin
        icpt_r   <= to_q1616(inum[PROD_W-1], div_big, div_quo);
        status_r <= w.limit ? STATUS_LIMIT : STATUS_OK;
      end
    end
    if (out_load) begin
      m_tdata <= {{(OUT_TDATA_W - 66){1'b0}}, status_r, icpt_r, slope_r};
    end
  end

endmodule

`default_nettype wire

[hdl/least_squares_line_fit.sv]
// Top level of the least-squares line fit: front accumulator, snapshot queue, fitting back end.
// Depends on lslf_pkg, lslf_front, lslf_queue, lslf_back (and lslf_mul, lslf_div below it).
//
//   port group | dir | tdata fields, lowest bit first                       | other
//   s_*        | in  | sample_x[15:0], sample_y[31:16]                      | tlast = last_pair
//   m_*        | out | slope[31:0], intercept[63:32], fit_status[65:64], 0s | -
//
// The front takes one pair per cycle; a squaring/product stage sits ahead of the sums.
// Each fit runs six serial 48x16-digit products and two 88-step restoring divisions; a fit
//   whose denominator is zero stops after the first two products and runs no division.
// Two sum snapshots wait in the queue; a last pair stalls only while the queue is full.
// Reset clears the running sums, the queue and the output valid at once.
`timescale 1ns / 1ps
`default_nettype none

module least_squares_line_fit import lslf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample_x[15:0], sample_y[31:16]
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // slope[31:0], intercept[63:32], fit_status[65:64]
);

  logic       push;
  lslf_sums_t push_data;
  logic       full;
  logic       pop;
  logic       q_valid;
  lslf_sums_t pop_data;

  lslf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  lslf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  lslf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

[hdl/lslf_checker.sv]
// Port-level checks for least_squares_line_fit, bound to the top level.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lslf_checker import lslf_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[65:64] <= STATUS_LIMIT)
    else $error("undefined fit status");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[65:64] == STATUS_DEGENERATE |-> m_tdata[63:0] == 64'd0)
    else $error("degenerate fit with nonzero slope or intercept");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:66] == '0)
    else $error("nonzero padding in result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for least_squares_line_fit: random stream traffic with stalls on both
// sides, an in-bench least-squares predictor and a result scoreboard. Depends on lslf_pkg.
`timescale 1ns / 1ps

module tb_top;
  import lslf_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } pair_t;

  typedef struct {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    lslf_status_t       status;
  } fit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  pair_t pairs_to_send[$];
  fit_t  fits_due[$];
  int    pairs_queued = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    send_hold = 0;
  int    recv_hold = 0;
  bit    calm = 1'b0;
  bit    pair_taken = 1'b0;
  pair_t next_pair;
  pair_t seen_pair;
  fit_t  due_fit;
  fit_t  got_fit;

  // running sums of the predictor
  logic [CNT_W-1:0]   pairs_seen = '0;
  logic signed [32:0] run_sx = '0;
  logic signed [32:0] run_sy = '0;
  logic signed [47:0] run_sxx = '0;
  logic signed [47:0] run_sxy = '0;
  logic               over_limit = 1'b0;

  least_squares_line_fit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] clamp_q1616(input logic signed [127:0] v);
    logic signed [127:0] q_max;
    logic signed [127:0] q_min;
    q_max = 128'sd2147483647;
    q_min = -q_max - 128'sd1;
    if (v > q_max) begin
      return 32'h7FFF_FFFF;
    end else if (v < q_min) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Fold one pair into the sums; on a last pair return the fit and clear.
  function automatic bit fold_pair(input pair_t p, output fit_t r);
    logic signed [127:0] n, sx, sy, sxx, sxy, den, snum, inum;
    r.slope = '0;
    r.intercept = '0;
    r.status = STATUS_DEGENERATE;
    if (pairs_seen < MAX_PAIRS) begin
      pairs_seen = pairs_seen + 1'b1;
      run_sx = run_sx + p.x;
      run_sy = run_sy + p.y;
      run_sxx = run_sxx + p.x * p.x;
      run_sxy = run_sxy + p.x * p.y;
    end else begin
      over_limit = 1'b1;
    end
    if (!p.last) begin
      return 1'b0;
    end
    n = pairs_seen;
    sx = run_sx;
    sy = run_sy;
    sxx = run_sxx;
    sxy = run_sxy;
    den = n * sxx - sx * sx;
    if (den != 0) begin
      snum = n * sxy - sx * sy;
      inum = sxx * sy - sx * sxy;
      r.slope = clamp_q1616((snum <<< 16) / den);
      r.intercept = clamp_q1616((inum <<< 8) / den);
      r.status = over_limit ? STATUS_LIMIT : STATUS_OK;
    end
    pairs_seen = '0;
    run_sx = '0;
    run_sy = '0;
    run_sxx = '0;
    run_sxy = '0;
    over_limit = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: pick_value = 16'sh8000;
      1: pick_value = 16'sh7FFF;
      2: pick_value = 16'($urandom_range(0, 32)) - 16'd16;
      default: pick_value = 16'($urandom);
    endcase
  endfunction

  task automatic push_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic last);
    pairs_to_send.push_back('{x, y, last});
    pairs_queued++;
  endtask

  // One data set: mostly noisy lines, some random clouds, some with a single x value.
  task automatic push_random_set();
    int len, kind, a, b, t;
    logic signed [15:0] fixed_x, x, y;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    kind = $urandom_range(0, 9);
    a = int'($urandom_range(0, 64)) - 32;
    b = int'($urandom_range(0, 2000)) - 1000;
    fixed_x = pick_value();
    for (int i = 0; i < len; i++) begin
      x = (kind == 0) ? fixed_x : pick_value();
      if (kind >= 4) begin
        t = a * x / 8 + b + int'($urandom_range(0, 64)) - 32;
        if (t > 32767) begin
          t = 32767;
        end else if (t < -32768) begin
          t = -32768;
        end
        y = 16'(t);
      end else begin
        y = pick_value();
      end
      push_pair(x, y, i == len - 1);
    end
  endtask

  task automatic wait_for_drain();
    while (pairs_to_send.size() != 0 || s_tvalid || fits_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || pair_taken) begin
        if (send_hold > 0) begin
          send_hold--;
          s_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          send_hold = $urandom_range(0, 17);
          s_tvalid <= 1'b0;
        end else if (pairs_to_send.size() != 0) begin
          next_pair = pairs_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {next_pair.y, next_pair.x};
          s_tlast <= next_pair.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_hold = $urandom_range(0, 17);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pair_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      seen_pair.x = s_tdata[15:0];
      seen_pair.y = s_tdata[31:16];
      seen_pair.last = s_tlast;
      if (fold_pair(seen_pair, due_fit)) begin
        fits_due.push_back(due_fit);
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      if (fits_due.size() == 0) begin
        $error("fit result with none expected: %h", m_tdata);
        mismatches++;
      end else begin
        got_fit = fits_due.pop_front();
        if (m_tdata[31:0] !== got_fit.slope) begin
          $error("slope: expected %0d, got %0d", got_fit.slope, $signed(m_tdata[31:0]));
          mismatches++;
        end
        if (m_tdata[63:32] !== got_fit.intercept) begin
          $error("intercept: expected %0d, got %0d", got_fit.intercept,
                 $signed(m_tdata[63:32]));
          mismatches++;
        end
        if (m_tdata[65:64] !== got_fit.status) begin
          $error("fit_status: expected %0d, got %0d", got_fit.status, m_tdata[65:64]);
          mismatches++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_pair(16'sd7, -16'sd3, 1'b1);
    push_pair(16'sh8000, 16'sd5, 1'b0);
    push_pair(16'sh8000, -16'sd9, 1'b1);
    push_pair(16'sd0, 16'sh8000, 1'b0);
    push_pair(16'sd1, 16'sh7FFF, 1'b1);
    push_pair(16'sd0, 16'sh7FFF, 1'b0);
    push_pair(16'sd1, 16'sh8000, 1'b1);
    push_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
    push_pair(16'sh7FFE, 16'sh8000, 1'b1);
    push_pair(16'sh8000, 16'sh8000, 1'b0);
    push_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    push_pair(-16'sd1, 16'sd0, 1'b0);
    push_pair(16'sd0, 16'sd256, 1'b0);
    push_pair(16'sd1, 16'sd512, 1'b1);
    push_pair(16'sh8000, 16'sh7FFF, 1'b0);
    push_pair(16'sh7FFF, 16'sh8000, 1'b0);
    push_pair(16'sd0, 16'sd0, 1'b0);
    push_pair(16'sh8000, 16'sh8000, 1'b1);
    push_pair(16'sd100, -16'sd1, 1'b0);
    push_pair(-16'sd100, -16'sd1, 1'b1);
    // hold the sender until every fit is back
    wait_for_drain();

    while (pairs_queued < 340) begin
      push_random_set();
    end
    while (pairs_to_send.size() != 0) begin
      @(posedge clk);
    end
    calm = 1'b1;
    while (pairs_queued < 400) begin
      push_random_set();
    end
    wait_for_drain();
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
